>>> rtl/core/assert_macros.svh
// Assertion helper macros for the easing range remap block.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset
`define ECRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold in the same cycle
`define ECRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ecrm_pkg.sv
// Shared types and constants for the easing range remap block.
// No dependencies; used by all modules of the block by scoped names.
`default_nettype none

package ecrm_pkg;

  // sample and range register width
  localparam int unsigned SMP_W = 16;
  // configuration data and index widths
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  // remainder width inside the divider (differences reach 17 bits, shifted once)
  localparam int unsigned DIV_RW = 18;
  // maximum number of squaring passes (step count 15 gives 14)
  localparam int unsigned MAX_SQ = 14;
  localparam int unsigned STEP_W = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_MIN   = 3'd0,
    REG_IN_MAX   = 3'd1,
    REG_OUT_MIN  = 3'd2,
    REG_OUT_MAX  = 3'd3,
    REG_CURVE    = 3'd4,
    REG_STEPS    = 3'd5
  } ecrm_reg_e;

  // easing curves
  typedef enum logic [2:0] {
    CRV_FLIP       = 3'd0,
    CRV_SQUARE     = 3'd1,
    CRV_ARCH       = 3'd2,
    CRV_START_ARCH = 3'd3,
    CRV_STOP_ARCH  = 3'd4,
    CRV_SMOOTH_IN  = 3'd5,
    CRV_SMOOTH_OUT = 3'd6,
    CRV_SMOOTH_STEP= 3'd7
  } ecrm_curve_e;

  // status flags that ride along with each transaction
  typedef struct packed {
    logic clamped;
    logic empty;
  } ecrm_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/ecrm_in_if.sv
// Input stream channel: valid/ready handshake with one signed sample.
// Depends on ecrm_pkg for the sample width.
`default_nettype none

interface ecrm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ecrm_pkg::SMP_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ecrm_out_if.sv
// Result stream channel: valid/ready handshake with mapped value and flags.
// Depends on ecrm_pkg for the sample width.
`default_nettype none

interface ecrm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ecrm_pkg::SMP_W-1:0]   mapped;
  logic                                clamped;
  logic                                empty_range;

  modport source (output valid, output mapped, output clamped, output empty_range,
                  input ready);
  modport sink   (input valid, input mapped, input clamped, input empty_range,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/easing_curve_range_map.sv
// Easing range remap block: samples in on smp_i, results out on res_o.
// Each sample is placed in [in_min, in_max] as a fraction t (FRAC_BITS fraction bits),
// saturated to [0,1], shaped by the selected easing curve and scaled onto
// [out_min, out_max] with saturation to signed 16 bits.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i only while no
// transaction is in flight (the block has no guard for this); writes to unused indexes are dropped.
// Pipeline stages: one entry stage and one divider stage per quotient bit, two
// product stages, 14 squaring stages, two blend stages and two output scaling stages.
// Throughput is one transaction per cycle; every stage is a register with a
// valid bit. When the receiver holds res_o.ready low while a result is
// waiting, the whole pipeline holds and smp_i.ready drops in the same cycle;
// no transaction is lost or repeated.
// Reset clears all valid bits and loads the register defaults: input and output
// range 0..32767, smoothstart curve, step count 2.
// Depends on ecrm_pkg, ecrm_in_if, ecrm_out_if, ecrm_div, ecrm_shape, ecrm_scale and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module easing_curve_range_map #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ecrm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [ecrm_pkg::CFG_W-1:0]            cfg_data_i,
  ecrm_in_if.sink                                    smp_i,
  ecrm_out_if.source                                 res_o
);

  localparam int unsigned SW = ecrm_pkg::SMP_W;
  localparam int unsigned NW = SW + 1;

  // configuration registers
  logic signed [SW-1:0]              in_min_q, in_max_q, out_min_q, out_max_q;
  ecrm_pkg::ecrm_curve_e             curve_q;
  logic [ecrm_pkg::STEP_W-1:0]       steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_min_q  <= '0;
      in_max_q  <= 16'sd32767;
      out_min_q <= '0;
      out_max_q <= 16'sd32767;
      curve_q   <= ecrm_pkg::CRV_SMOOTH_IN;
      steps_q   <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ecrm_pkg::REG_IN_MIN:  in_min_q  <= cfg_data_i;
        ecrm_pkg::REG_IN_MAX:  in_max_q  <= cfg_data_i;
        ecrm_pkg::REG_OUT_MIN: out_min_q <= cfg_data_i;
        ecrm_pkg::REG_OUT_MAX: out_max_q <= cfg_data_i;
        ecrm_pkg::REG_CURVE:   curve_q   <= ecrm_pkg::ecrm_curve_e'(cfg_data_i[2:0]);
        ecrm_pkg::REG_STEPS:   steps_q   <= cfg_data_i[ecrm_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: hold everything while a result waits on a stalled sink
  logic en;
  assign en          = !res_o.valid || res_o.ready;
  assign smp_i.ready = en;

  // input classification: distance from in_min against the range span
  logic signed [NW-1:0]  num, den;
  logic [NW-1:0]         an, ad;
  logic                  empty, neg, over, sat_one;
  ecrm_pkg::ecrm_flags_t flags_in;

  assign num   = NW'(smp_i.sample) - NW'(in_min_q);
  assign den   = NW'(in_max_q) - NW'(in_min_q);
  assign an    = num[NW-1] ? NW'(-num) : num;
  assign ad    = den[NW-1] ? NW'(-den) : den;
  assign empty = (den == '0);
  assign neg   = (num != '0) && (num[NW-1] != den[NW-1]);
  assign over  = (an > ad);
  assign sat_one = !neg && (an >= ad);

  assign flags_in.clamped = !empty && (neg || over);
  assign flags_in.empty   = empty;

  logic                  div_v;
  logic [FRAC_BITS:0]    div_t;
  ecrm_pkg::ecrm_flags_t div_fl;

  ecrm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (smp_i.valid),
    .an_i       (an),
    .ad_i       (ad),
    .sat_zero_i (neg || empty),
    .sat_one_i  (sat_one && !empty),
    .flags_i    (flags_in),
    .valid_o    (div_v),
    .t_o        (div_t),
    .flags_o    (div_fl)
  );

  logic                  shp_v;
  logic [FRAC_BITS:0]    shp_y;
  ecrm_pkg::ecrm_flags_t shp_fl;

  ecrm_shape #(.FRAC_BITS(FRAC_BITS)) u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v),
    .t_i     (div_t),
    .flags_i (div_fl),
    .curve_i (curve_q),
    .steps_i (steps_q),
    .valid_o (shp_v),
    .y_o     (shp_y),
    .flags_o (shp_fl)
  );

  ecrm_pkg::ecrm_flags_t out_fl;

  ecrm_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (shp_v),
    .y_i       (shp_y),
    .flags_i   (shp_fl),
    .out_min_i (out_min_q),
    .out_max_i (out_max_q),
    .valid_o   (res_o.valid),
    .mapped_o  (res_o.mapped),
    .flags_o   (out_fl)
  );

  assign res_o.clamped     = out_fl.clamped;
  assign res_o.empty_range = out_fl.empty;

  // checks
  `ECRM_ASSERT_IMP(a_empty_not_clamped, res_o.valid && res_o.empty_range, !res_o.clamped, "empty range result flagged as clamped")
  `ECRM_ASSERT_IMP(a_empty_gives_min, res_o.valid && res_o.empty_range, res_o.mapped == out_min_q, "empty range result differs from out_min")
  `ECRM_ASSERT(a_stall_blocks_input, !(res_o.valid && !res_o.ready && smp_i.ready), "input accepted while output stalled")

endmodule

`default_nettype wire

>>> rtl/core/ecrm_div.sv
// Pipelined restoring divider: t = floor(an * 2^FRAC_BITS / ad), or 0 / 1.0 when saturated; one quotient bit per stage.
// Depends on ecrm_pkg.
`default_nettype none

module ecrm_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [ecrm_pkg::DIV_RW-2:0]   an_i,
  input  wire logic [ecrm_pkg::DIV_RW-2:0]   ad_i,
  input  wire logic                          sat_zero_i,
  input  wire logic                          sat_one_i,
  input  wire ecrm_pkg::ecrm_flags_t         flags_i,
  output logic                               valid_o,
  output logic [FRAC_BITS:0]                 t_o,
  output ecrm_pkg::ecrm_flags_t              flags_o
);

  localparam int unsigned RW = ecrm_pkg::DIV_RW;
  localparam int unsigned NS = FRAC_BITS + 1;

  logic                    v_q  [NS];
  logic [RW-1:0]           r_q  [NS];
  logic [RW-2:0]           d_q  [NS];
  logic [FRAC_BITS-1:0]    q_q  [NS];
  logic                    one_q[NS];
  ecrm_pkg::ecrm_flags_t   fl_q [NS];

  // entry stage: saturated cases start from a zero remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= (sat_zero_i || sat_one_i) ? '0 : {1'b0, an_i};
      d_q[0]   <= ad_i;
      q_q[0]   <= '0;
      one_q[0] <= sat_one_i;
      fl_q[0]  <= flags_i;
    end
  end

  // one trial subtraction per stage
  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {r_q[k-1][RW-2:0], 1'b0};
    assign ge    = (trial >= {1'b0, d_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? (trial - {1'b0, d_q[k-1]}) : trial;
        d_q[k]   <= d_q[k-1];
        q_q[k]   <= {q_q[k-1][FRAC_BITS-2:0], ge};
        one_q[k] <= one_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign t_o     = one_q[NS-1] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q_q[NS-1]};
  assign flags_o = fl_q[NS-1];

endmodule

`default_nettype wire

>>> rtl/core/ecrm_shape.sv
// Easing curve pipeline: products, repeated squaring chain and smoothstep blend.
// Depends on ecrm_pkg.
`default_nettype none

module ecrm_shape #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [FRAC_BITS:0]            t_i,
  input  wire ecrm_pkg::ecrm_flags_t         flags_i,
  input  wire ecrm_pkg::ecrm_curve_e         curve_i,
  input  wire logic [ecrm_pkg::STEP_W-1:0]   steps_i,
  output logic                               valid_o,
  output logic [FRAC_BITS:0]                 y_o,
  output ecrm_pkg::ecrm_flags_t              flags_o
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NQ = ecrm_pkg::MAX_SQ;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage A: first-level products
  logic [W-1:0]  u_a;
  logic [PW-1:0] tt_p, uu_p, tu_p;
  logic          va_q;
  logic [W-1:0]  ta_q, ua_q, tta_q, uua_q, tua_q;
  ecrm_pkg::ecrm_flags_t fla_q;

  assign u_a  = ONE - t_i;
  assign tt_p = t_i * t_i;
  assign uu_p = u_a * u_a;
  assign tu_p = t_i * u_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q  <= t_i;
      ua_q  <= u_a;
      tta_q <= tt_p[FRAC_BITS +: W];
      uua_q <= uu_p[FRAC_BITS +: W];
      tua_q <= tu_p[FRAC_BITS +: W];
      fla_q <= flags_i;
    end
  end

  // stage B: cubic arches and selection of the simple curves
  logic [PW-1:0] ttu_p, tuu_p;
  logic [W-1:0]  simple_b;

  assign ttu_p = tta_q * ua_q;
  assign tuu_p = ta_q * uua_q;

  always_comb begin
    case (curve_i)
      ecrm_pkg::CRV_FLIP:       simple_b = ua_q;
      ecrm_pkg::CRV_SQUARE:     simple_b = tta_q;
      ecrm_pkg::CRV_ARCH:       simple_b = tua_q;
      ecrm_pkg::CRV_START_ARCH: simple_b = ttu_p[FRAC_BITS +: W];
      ecrm_pkg::CRV_STOP_ARCH:  simple_b = tuu_p[FRAC_BITS +: W];
      default:                  simple_b = ta_q;
    endcase
  end

  logic                  v_q  [NQ+1];
  logic [W-1:0]          t_q  [NQ+1];
  logic [W-1:0]          x_q  [NQ+1];
  logic [W-1:0]          y_q  [NQ+1];
  logic [W-1:0]          s_q  [NQ+1];
  ecrm_pkg::ecrm_flags_t fl_q [NQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0]  <= ta_q;
      x_q[0]  <= ta_q;
      y_q[0]  <= ua_q;
      s_q[0]  <= simple_b;
      fl_q[0] <= fla_q;
    end
  end

  // squaring chain: pass k squares when k is below the step count
  for (genvar k = 1; k <= NQ; k++) begin : g_sq
    logic [PW-1:0] xx, yy;
    logic          act;

    assign xx  = x_q[k-1] * x_q[k-1];
    assign yy  = y_q[k-1] * y_q[k-1];
    assign act = (ecrm_pkg::STEP_W'(k) < steps_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[k]  <= t_q[k-1];
        x_q[k]  <= act ? xx[FRAC_BITS +: W] : x_q[k-1];
        y_q[k]  <= act ? yy[FRAC_BITS +: W] : y_q[k-1];
        s_q[k]  <= s_q[k-1];
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // stage C: smoothstart a, smoothstop b and t*|b-a|
  logic [W-1:0]  b_c;
  logic [W:0]    d_c;
  logic          neg_c;
  logic [W-1:0]  mag_c;
  logic [PW-1:0] prod_c;

  assign b_c    = ONE - y_q[NQ];
  assign d_c    = {1'b0, b_c} - {1'b0, x_q[NQ]};
  assign neg_c  = d_c[W];
  assign mag_c  = neg_c ? W'(-d_c) : d_c[W-1:0];
  assign prod_c = t_q[NQ] * mag_c;

  logic                  vc_q;
  logic [W-1:0]          ac_q, bc_q, sc_q;
  logic                  negc_q;
  logic [PW-1:0]         prodc_q;
  ecrm_pkg::ecrm_flags_t flc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= v_q[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q    <= x_q[NQ];
      bc_q    <= b_c;
      sc_q    <= s_q[NQ];
      negc_q  <= neg_c;
      prodc_q <= prod_c;
      flc_q   <= fl_q[NQ];
    end
  end

  // stage D: blend with floor rounding and final curve selection
  logic [PW:0]   up_d;
  logic [W-1:0]  step_d;
  logic [W-1:0]  y_d;

  assign up_d   = {1'b0, prodc_q} + (PW+1)'(ONE - 1'b1);
  assign step_d = negc_q ? (ac_q - up_d[FRAC_BITS +: W]) : (ac_q + prodc_q[FRAC_BITS +: W]);

  always_comb begin
    case (curve_i)
      ecrm_pkg::CRV_SMOOTH_IN:   y_d = ac_q;
      ecrm_pkg::CRV_SMOOTH_OUT:  y_d = bc_q;
      ecrm_pkg::CRV_SMOOTH_STEP: y_d = step_d;
      default:                   y_d = sc_q;
    endcase
  end

  logic                  vd_q;
  logic [W-1:0]          yd_q;
  ecrm_pkg::ecrm_flags_t fld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yd_q  <= y_d;
      fld_q <= flc_q;
    end
  end

  assign valid_o = vd_q;
  assign y_o     = yd_q;
  assign flags_o = fld_q;

endmodule

`default_nettype wire

>>> rtl/core/ecrm_scale.sv
// Output scaler: out_min + floor(y * (out_max - out_min) / ONE), saturated to 16 bits, or out_min for an empty range.
// Depends on ecrm_pkg. Its second register is the block's output register.
`default_nettype none

module ecrm_scale #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [FRAC_BITS:0]                y_i,
  input  wire ecrm_pkg::ecrm_flags_t             flags_i,
  input  wire logic signed [ecrm_pkg::SMP_W-1:0] out_min_i,
  input  wire logic signed [ecrm_pkg::SMP_W-1:0] out_max_i,
  output logic                                   valid_o,
  output logic signed [ecrm_pkg::SMP_W-1:0]      mapped_o,
  output ecrm_pkg::ecrm_flags_t                  flags_o
);

  localparam int unsigned SW = ecrm_pkg::SMP_W;
  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned MW = SW + 1;
  localparam int unsigned PW = W + MW;

  // stage 1: range span and its product with y
  logic signed [MW-1:0] diff;
  logic [MW-1:0]        mag;
  logic [PW-1:0]        prod;

  assign diff = MW'(out_max_i) - MW'(out_min_i);
  assign mag  = diff[MW-1] ? MW'(-diff) : diff;
  assign prod = y_i * mag;

  logic                  v1_q, neg1_q;
  logic [PW-1:0]         prod1_q;
  ecrm_pkg::ecrm_flags_t fl1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= diff[MW-1];
      prod1_q <= prod;
      fl1_q   <= flags_i;
    end
  end

  // stage 2: floor rounding, offset and saturation
  logic [PW:0]          up;
  logic [MW-1:0]        qmag;
  logic signed [MW:0]   sum;
  logic signed [SW-1:0] sat;

  assign up   = {1'b0, prod1_q} + (PW+1)'({FRAC_BITS{1'b1}});
  assign qmag = neg1_q ? up[FRAC_BITS +: MW] : prod1_q[FRAC_BITS +: MW];
  assign sum  = neg1_q ? ((MW+1)'(out_min_i) - (MW+1)'(qmag))
                       : ((MW+1)'(out_min_i) + (MW+1)'(qmag));

  always_comb begin
    if (sum > (MW+1)'(32767)) begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end else if (sum < -(MW+1)'(32768)) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = sum[SW-1:0];
    end
  end

  logic                  v2_q;
  logic signed [SW-1:0]  mapped_q;
  ecrm_pkg::ecrm_flags_t fl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mapped_q <= fl1_q.empty ? out_min_i : sat;
      fl2_q    <= fl1_q;
    end
  end

  assign valid_o  = v2_q;
  assign mapped_o = mapped_q;
  assign flags_o  = fl2_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the easing range remap block.
// Needs ecrm_pkg, ecrm_in_if, ecrm_out_if and easing_curve_range_map.
// Samples are predicted in the bench and compared with every result transaction.
`default_nettype none

module testbench;

  localparam int unsigned FRAC = 16;
  localparam longint     ONE_Q = longint'(1) << FRAC;
  localparam int         LATENCY = FRAC + 21;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_ITEMS = 1200;
  localparam logic [ecrm_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [ecrm_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] mapped;
    logic               clamped;
    logic               empty_range;
  } remap_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ecrm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ecrm_pkg::CFG_W-1:0]     cfg_data_i = '0;

  ecrm_in_if  smp_if ();
  ecrm_out_if res_if ();

  easing_curve_range_map #(.FRAC_BITS(FRAC)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp_if.sink),
    .res_o      (res_if.source)
  );

  // bench copy of the registers
  longint cur_in_min, cur_in_max, cur_out_min, cur_out_max;
  logic [2:0] cur_curve;
  logic [3:0] cur_steps;

  remap_res_t pending_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_clamped = 0;
  int n_empty = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    res_if.ready = 1'b0;
  end

  // model of the register file
  task automatic apply_reg(logic [ecrm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ecrm_pkg::CFG_W-1:0] data);
    case (idx)
      ecrm_pkg::REG_IN_MIN:  cur_in_min  = longint'($signed(data));
      ecrm_pkg::REG_IN_MAX:  cur_in_max  = longint'($signed(data));
      ecrm_pkg::REG_OUT_MIN: cur_out_min = longint'($signed(data));
      ecrm_pkg::REG_OUT_MAX: cur_out_max = longint'($signed(data));
      ecrm_pkg::REG_CURVE:   cur_curve   = data[2:0];
      ecrm_pkg::REG_STEPS:   cur_steps   = data[3:0];
      default: ;
    endcase
  endtask

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint square_n(longint x);
    longint v;
    v = x;
    for (int i = 1; i < cur_steps; i++) v = qmul(v, v);
    return v;
  endfunction

  // floor(f*d/ONE) with a signed d
  function automatic longint scale_frac(longint f, longint d);
    if (d >= 0) return (f * d) >>> FRAC;
    return -(((f * -d) + ONE_Q - 1) >>> FRAC);
  endfunction

  function automatic longint ease(longint t);
    longint u, a, b;
    u = ONE_Q - t;
    case (ecrm_pkg::ecrm_curve_e'(cur_curve))
      ecrm_pkg::CRV_FLIP:       return u;
      ecrm_pkg::CRV_SQUARE:     return qmul(t, t);
      ecrm_pkg::CRV_ARCH:       return qmul(t, u);
      ecrm_pkg::CRV_START_ARCH: return qmul(qmul(t, t), u);
      ecrm_pkg::CRV_STOP_ARCH:  return qmul(t, qmul(u, u));
      ecrm_pkg::CRV_SMOOTH_IN:  return square_n(t);
      ecrm_pkg::CRV_SMOOTH_OUT: return ONE_Q - square_n(u);
      default: begin
        a = square_n(t);
        b = ONE_Q - square_n(u);
        return a + scale_frac(t, b - a);
      end
    endcase
  endfunction

  function automatic remap_res_t predict_remap(logic signed [15:0] s);
    remap_res_t r;
    longint num, den, an, ad, t, y, m;
    r = '0;
    num = longint'(s) - cur_in_min;
    den = cur_in_max - cur_in_min;
    if (den == 0) begin
      r.mapped = cur_out_min[15:0];
      r.empty_range = 1'b1;
      return r;
    end
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (num != 0 && ((num < 0) != (den < 0))) begin
      t = 0;
      r.clamped = 1'b1;
    end else if (an > ad) begin
      t = ONE_Q;
      r.clamped = 1'b1;
    end else begin
      t = (an * ONE_Q) / ad;
    end
    y = ease(t);
    m = cur_out_min + scale_frac(y, cur_out_max - cur_out_min);
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    r.mapped = m[15:0];
    return r;
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        res_if.ready = 1'b1;
        n = $urandom_range(1, 30);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    remap_res_t want, got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.mapped = res_if.mapped;
      got.clamped = res_if.clamped;
      got.empty_range = res_if.empty_range;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: mapped exp %0d got %0d, clamped exp %b got %b, empty exp %b got %b",
                     n_checked, want.mapped, got.mapped, want.clamped, got.clamped,
                     want.empty_range, got.empty_range);
        end
      end
    end
  end

  // one sample transaction, with an optional gap before it
  task automatic send_sample(logic signed [15:0] s);
    remap_res_t e;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      smp_if.valid = 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    smp_if.valid = 1'b1;
    smp_if.sample = s;
    do @(posedge clk_i); while (!smp_if.ready);
    e = predict_remap(s);
    if (e.clamped) n_clamped++;
    if (e.empty_range) n_empty++;
    pending_q.push_back(e);
    n_sent++;
  endtask

  // drain the pipeline so registers can change safely
  task automatic wait_idle();
    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ecrm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ecrm_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_ranges(int imin, int imax, int omin, int omax);
    write_reg(ecrm_pkg::REG_IN_MIN, imin[15:0]);
    write_reg(ecrm_pkg::REG_IN_MAX, imax[15:0]);
    write_reg(ecrm_pkg::REG_OUT_MIN, omin[15:0]);
    write_reg(ecrm_pkg::REG_OUT_MAX, omax[15:0]);
  endtask

  // reset values with the extremes of the sample
  task automatic test_reset_defaults();
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd16384);
    send_sample(16'sh7fff);
  endtask

  // each curve at sample 12000, full signed ranges
  task automatic test_all_curves();
    wait_idle();
    set_ranges(-32768, 32767, -32768, 32767);
    write_reg(ecrm_pkg::REG_STEPS, 16'd3);
    for (int c = 0; c < 8; c++) begin
      write_reg(ecrm_pkg::REG_CURVE, ecrm_pkg::CFG_W'(c));
      send_sample(16'sd12000);
      wait_idle();
    end
  endtask

  // reversed and empty ranges, out of range on both sides
  task automatic test_range_cases();
    set_ranges(1000, -1000, 32767, -32768);
    write_reg(ecrm_pkg::REG_CURVE, ecrm_pkg::CFG_W'(ecrm_pkg::CRV_SMOOTH_STEP));
    send_sample(16'sd2000);
    send_sample(-16'sd2000);
    send_sample(16'sd1000);
    send_sample(16'sd0);
    wait_idle();
    set_ranges(-500, -500, -1234, 77);
    send_sample(-16'sd500);
    send_sample(16'sh7fff);
    wait_idle();
  endtask

  // step counts zero, one, eight and fifteen, spare indexes ignored
  task automatic test_step_counts();
    logic [3:0] stp [4] = '{4'd0, 4'd1, 4'd8, 4'd15};
    set_ranges(0, 32767, 0, 32767);
    write_reg(REG_SPARE_6, 16'hffff);
    write_reg(REG_SPARE_7, 16'h1234);
    for (int k = 0; k < 4; k++) begin
      write_reg(ecrm_pkg::REG_STEPS, {12'hfff, stp[k]});
      write_reg(ecrm_pkg::REG_CURVE, {13'h1fff, ecrm_pkg::CRV_SMOOTH_OUT});
      send_sample(16'sd20000);
      wait_idle();
    end
  endtask

  function automatic logic signed [15:0] pick_sample();
    int lo, hi;
    lo = (cur_in_min < cur_in_max) ? int'(cur_in_min) : int'(cur_in_max);
    hi = (cur_in_min < cur_in_max) ? int'(cur_in_max) : int'(cur_in_min);
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(hi - lo, 0) + lo);
    return 16'($urandom());
  endfunction

  function automatic int pick_bound();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  // random configurations with mostly in-range samples
  task automatic test_random_stream();
    int b0, b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        wait_idle();
        b0 = pick_bound();
        b1 = ($urandom_range(0, 19) == 0) ? b0 : pick_bound();
        set_ranges(b0, b1, pick_bound(), pick_bound());
        write_reg(ecrm_pkg::REG_CURVE, 16'($urandom()));
        write_reg(ecrm_pkg::REG_STEPS, ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                       : ecrm_pkg::CFG_W'($urandom_range(1, 8)));
      end
      if (i == 550) wait_idle();
      if (i == RANDOM_ITEMS - 150) idle_on = 1'b0;
      send_sample(pick_sample());
    end
  endtask

  initial begin
    apply_reg(ecrm_pkg::REG_IN_MIN, 16'd0);
    apply_reg(ecrm_pkg::REG_IN_MAX, 16'd32767);
    apply_reg(ecrm_pkg::REG_OUT_MIN, 16'd0);
    apply_reg(ecrm_pkg::REG_OUT_MAX, 16'd32767);
    apply_reg(ecrm_pkg::REG_CURVE, ecrm_pkg::CFG_W'(ecrm_pkg::CRV_SMOOTH_IN));
    apply_reg(ecrm_pkg::REG_STEPS, 16'd2);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_all_curves();
    test_range_cases();
    test_step_counts();
    test_random_stream();

    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("sent %0d samples over all eight curves and several ranges, %0d results checked",
             n_sent, n_checked);
    $display("%0d saturated fractions, %0d empty input ranges", n_clamped, n_empty);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, pending_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
